@@ design/swish_activation_and_gradient_macros.svh @@
// Assertion macros shared by the swish pipeline modules.
// Expects clk and rst_n in the scope of each use.
`ifndef SWISH_ACTIVATION_AND_GRADIENT_MACROS_SVH
`define SWISH_ACTIVATION_AND_GRADIENT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SWISH_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define SWISH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/swish_pkg.sv @@
// Shared constants, word types and the sigmoid table for the swish pipeline.
// No dependencies.
package swish_pkg;

    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES + 1);
    localparam int SIG_W       = 17;
    localparam int DATA_W      = 16;
    localparam int POS_W       = 12;
    localparam int SCALE_W     = POS_W + SIG_IDX_W;
    localparam int G_W         = 20;

    localparam logic [SIG_W-1:0] SIG_ONE = SIG_W'(65536);

    typedef logic [SIG_W-1:0] sig_rom_t [0:SIG_ENTRIES];

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] up;
        logic signed [DATA_W-1:0] acc;
        logic        [SIG_W-1:0]  sig;
    } swish_sig_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] act;
        logic signed [DATA_W-1:0] grad;
        logic                     ovf;
    } swish_res_word_t;

    // Shift-subtract quotient, evaluated at elaboration only
    function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sigmoid over [-8,8] in unsigned Q1.16, entry i at -8 + 16*i/SIG_ENTRIES
    function automatic sig_rom_t build_sig_rom();
        sig_rom_t    rom;
        logic [63:0] n;
        logic [63:0] term;
        logic [63:0] q;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] hi;
        logic [63:0] i;
        n    = 64'(SIG_ENTRIES);
        term = 64'd1 << 30;
        q    = 64'd1 << 30;
        e    = 64'd1 << 30;
        for (int k = 1; k <= 15; k++)
        begin
            term = const_udiv(term * 64'd8, n * 64'(k));
            if ((k % 2) == 1)
                q = q - term;
            else
                q = q + term;
        end
        for (int k = 0; k <= SIG_ENTRIES; k++)
        begin
            d  = (64'd1 << 30) + e;
            hi = const_udiv((64'd1 << 46) + (d >> 1), d);
            if (((n + 64'(k)) & 64'd1) == 64'd0)
            begin
                i                = (n + 64'(k)) >> 1;
                rom[int'(i)]     = SIG_W'(hi);
                rom[int'(n - i)] = SIG_W'(64'd65536 - hi);
            end
            e = (e * q + (64'd1 << 29)) >> 30;
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

@@ design/swish_sigmoid.sv @@
// Three-stage sigmoid: table index, table read, linear interpolation.
// Depends on swish_pkg and the assertion macro header.
`include "swish_activation_and_gradient_macros.svh"

module swish_sigmoid (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic signed [15:0]              x_value,
    input  logic signed [15:0]              upstream_grad,
    input  logic signed [15:0]              grad_accum_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output swish_pkg::swish_sig_word_t      out_word
);
    import swish_pkg::*;

    localparam logic signed [DATA_W-1:0] X_LO       = -16'sd2048;
    localparam logic signed [DATA_W-1:0] X_HI       = 16'sd2048;
    localparam logic signed [DATA_W:0]   POS_OFFSET = 17'sd2048;
    localparam int                       PROD_W     = SIG_W + POS_W;
    localparam logic [PROD_W-1:0]        INTERP_HALF = PROD_W'(2048);

    logic en1, en2, en3;

    // stage 1
    logic                     vld1_reg;
    logic                     mode1_reg;
    logic signed [DATA_W-1:0] x1_reg, up1_reg, acc1_reg;
    logic [SIG_IDX_W-1:0]     idx1_reg;
    logic [POS_W-1:0]         frac1_reg;
    logic                     lo1_reg, hi1_reg;
    logic signed [DATA_W:0]   pos_full;
    logic [SCALE_W-1:0]       scaled_next;

    // stage 2
    logic                     vld2_reg;
    logic                     mode2_reg;
    logic signed [DATA_W-1:0] x2_reg, up2_reg, acc2_reg;
    logic [SIG_W-1:0]         a2_reg, b2_reg;
    logic [POS_W-1:0]         frac2_reg;
    logic                     lo2_reg, hi2_reg;
    logic [SIG_IDX_W-1:0]     idx_plus;

    // stage 3
    logic                     vld3_reg;
    logic                     mode3_reg;
    logic signed [DATA_W-1:0] x3_reg, up3_reg, acc3_reg;
    logic [SIG_W-1:0]         sig3_reg;
    logic [SIG_W-1:0]         diff;
    logic [PROD_W-1:0]        interp_prod;
    logic [PROD_W-1:0]        interp_rnd;
    logic [SIG_W-1:0]         sig_next;

    assign en3      = !vld3_reg || !out_stall;
    assign en2      = !vld2_reg || en3;
    assign en1      = !vld1_reg || en2;
    assign in_stall = !en1;

    always_comb
    begin
        pos_full    = (DATA_W + 1)'(x_value) + POS_OFFSET;
        scaled_next = SCALE_W'(pos_full[POS_W-1:0]) * SCALE_W'(SIG_ENTRIES);
    end

    assign idx_plus = idx1_reg + SIG_IDX_W'(1);

    always_comb
    begin
        diff        = (b2_reg > a2_reg) ? (b2_reg - a2_reg) : '0;
        interp_prod = PROD_W'(diff) * PROD_W'(frac2_reg);
        interp_rnd  = interp_prod + INTERP_HALF;
        if (lo2_reg)
            sig_next = '0;
        else if (hi2_reg)
            sig_next = SIG_ONE;
        else
            sig_next = a2_reg + SIG_W'(interp_rnd >> POS_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                vld1_reg <= in_valid;
            if (en2)
                vld2_reg <= vld1_reg;
            if (en3)
                vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mode1_reg <= mode;
            x1_reg    <= x_value;
            up1_reg   <= upstream_grad;
            acc1_reg  <= grad_accum_in;
            idx1_reg  <= scaled_next[SCALE_W-1:POS_W];
            frac1_reg <= scaled_next[POS_W-1:0];
            lo1_reg   <= (x_value < X_LO);
            hi1_reg   <= (x_value >= X_HI);
        end
        if (en2)
        begin
            mode2_reg <= mode1_reg;
            x2_reg    <= x1_reg;
            up2_reg   <= up1_reg;
            acc2_reg  <= acc1_reg;
            a2_reg    <= SIG_ROM[idx1_reg];
            b2_reg    <= SIG_ROM[idx_plus];
            frac2_reg <= frac1_reg;
            lo2_reg   <= lo1_reg;
            hi2_reg   <= hi1_reg;
        end
        if (en3)
        begin
            mode3_reg <= mode2_reg;
            x3_reg    <= x2_reg;
            up3_reg   <= up2_reg;
            acc3_reg  <= acc2_reg;
            sig3_reg  <= sig_next;
        end
    end

    assign out_valid     = vld3_reg;
    assign out_word.mode = mode3_reg;
    assign out_word.x    = x3_reg;
    assign out_word.up   = up3_reg;
    assign out_word.acc  = acc3_reg;
    assign out_word.sig  = sig3_reg;

    `SWISH_ASSERT_IMPL(a_sig_range, vld3_reg, sig3_reg <= SIG_ONE, "sigmoid above one")
    `SWISH_ASSERT_IMPL(a_sig_low, vld3_reg && (x3_reg < X_LO), sig3_reg == '0, "sigmoid not zero below range")
    `SWISH_ASSERT_IMPL(a_sig_high, vld3_reg && (x3_reg >= X_HI), sig3_reg == SIG_ONE, "sigmoid not one above range")
    `SWISH_ASSERT_NEXT(a_sig_hold, vld3_reg && out_stall, vld3_reg && $stable(sig3_reg), "stalled sigmoid word moved")

endmodule

@@ design/swish_grad.sv @@
// Five-stage product chain: activation, gradient factor, scaled gradient, accumulate.
// Depends on swish_pkg and the assertion macro header.
`include "swish_activation_and_gradient_macros.svh"

module swish_grad (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  swish_pkg::swish_sig_word_t      in_word,
    output logic                            out_valid,
    input  logic                            out_stall,
    output swish_pkg::swish_res_word_t      out_word
);
    import swish_pkg::*;

    localparam int PROD_W  = 34;
    localparam int ACT_W   = 18;
    localparam int INNER_W = 30;
    localparam int GP_W    = 48;
    localparam int TP_W    = 36;
    localparam int SUM_W   = 21;

    localparam logic signed [PROD_W-1:0]  ACT_HALF   = PROD_W'(32768);
    localparam logic signed [INNER_W-1:0] INNER_ONE  = INNER_W'(1 << 24);
    localparam logic signed [GP_W-1:0]    G_HALF     = GP_W'(1 << 23);
    localparam logic signed [TP_W-1:0]    T_HALF     = TP_W'(32768);
    localparam logic signed [ACT_W-1:0]   ACT_MAX    = ACT_W'(32767);
    localparam logic signed [ACT_W-1:0]   ACT_MIN    = -ACT_W'(32768);
    localparam logic signed [SUM_W-1:0]   SUM_MAX    = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0]   SUM_MIN    = -SUM_W'(32768);
    localparam logic signed [DATA_W-1:0]  Q_MAX      = 16'sh7fff;
    localparam logic signed [DATA_W-1:0]  Q_MIN      = 16'sh8000;

    logic en4, en5, en6, en7, en8;

    // stage 4: x*sig and x*(1-sig)
    logic                      vld4_reg, mode4_reg;
    logic signed [DATA_W-1:0]  up4_reg, acc4_reg;
    logic [SIG_W-1:0]          sig4_reg;
    logic signed [PROD_W-1:0]  xs4_reg, xom4_reg;
    logic signed [SIG_W:0]     sig_in_s, om_s;
    logic [SIG_W-1:0]          om;
    logic signed [PROD_W-1:0]  xs_next, xom_next;

    // stage 5: activation, gradient inner term
    logic                      vld5_reg, mode5_reg;
    logic signed [DATA_W-1:0]  up5_reg, acc5_reg;
    logic [SIG_W-1:0]          sig5_reg;
    logic signed [DATA_W-1:0]  act5_reg;
    logic                      ovf5_reg;
    logic signed [INNER_W-1:0] inner5_reg;
    logic signed [PROD_W-1:0]  act_rnd;
    logic signed [ACT_W-1:0]   act_full;
    logic signed [DATA_W-1:0]  act_next;
    logic                      act_ovf_next;
    logic signed [INNER_W-1:0] inner_next;

    // stage 6: gradient factor
    logic                      vld6_reg, mode6_reg;
    logic signed [DATA_W-1:0]  up6_reg, acc6_reg, act6_reg;
    logic                      ovf6_reg;
    logic signed [G_W-1:0]     g6_reg;
    logic signed [SIG_W:0]     sig5_s;
    logic signed [GP_W-1:0]    gp_rnd;
    logic signed [G_W-1:0]     g_next;

    // stage 7: factor times upstream gradient
    logic                      vld7_reg, mode7_reg;
    logic signed [DATA_W-1:0]  acc7_reg, act7_reg;
    logic                      ovf7_reg;
    logic signed [TP_W-1:0]    tp7_reg;
    logic signed [TP_W-1:0]    tp_next;

    // stage 8: accumulate and saturate
    logic                      vld8_reg;
    logic signed [DATA_W-1:0]  act8_reg, grad8_reg;
    logic                      ovf8_reg, mode8_reg;
    logic signed [G_W-1:0]     t_val;
    logic signed [SUM_W-1:0]   sum;
    logic signed [DATA_W-1:0]  grad_next;
    logic                      ovf_next;

    assign en8      = !vld8_reg || !out_stall;
    assign en7      = !vld7_reg || en8;
    assign en6      = !vld6_reg || en7;
    assign en5      = !vld5_reg || en6;
    assign en4      = !vld4_reg || en5;
    assign in_stall = !en4;

    always_comb
    begin
        om       = SIG_ONE - in_word.sig;
        sig_in_s = $signed({1'b0, in_word.sig});
        om_s     = $signed({1'b0, om});
        xs_next  = PROD_W'($signed(in_word.x)) * PROD_W'(sig_in_s);
        xom_next = PROD_W'($signed(in_word.x)) * PROD_W'(om_s);
    end

    always_comb
    begin
        act_rnd = xs4_reg + ACT_HALF;
        act_full = ACT_W'(act_rnd >>> 16);
        if (act_full > ACT_MAX)
        begin
            act_next     = Q_MAX;
            act_ovf_next = 1'b1;
        end
        else if (act_full < ACT_MIN)
        begin
            act_next     = Q_MIN;
            act_ovf_next = 1'b1;
        end
        else
        begin
            act_next     = DATA_W'(act_full);
            act_ovf_next = 1'b0;
        end
        inner_next = INNER_W'(xom4_reg) + INNER_ONE;
    end

    always_comb
    begin
        sig5_s = $signed({1'b0, sig5_reg});
        gp_rnd = GP_W'(sig5_s) * GP_W'(inner5_reg) + G_HALF;
        g_next = G_W'(gp_rnd >>> 24);
    end

    assign tp_next = TP_W'(g6_reg) * TP_W'(up6_reg);

    always_comb
    begin
        t_val = G_W'((tp7_reg + T_HALF) >>> 16);
        sum   = SUM_W'(acc7_reg) + SUM_W'(t_val);
        if (!mode7_reg)
        begin
            grad_next = '0;
            ovf_next  = ovf7_reg;
        end
        else if (sum > SUM_MAX)
        begin
            grad_next = Q_MAX;
            ovf_next  = 1'b1;
        end
        else if (sum < SUM_MIN)
        begin
            grad_next = Q_MIN;
            ovf_next  = 1'b1;
        end
        else
        begin
            grad_next = DATA_W'(sum);
            ovf_next  = ovf7_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
            vld8_reg <= 1'b0;
        end
        else
        begin
            if (en4)
                vld4_reg <= in_valid;
            if (en5)
                vld5_reg <= vld4_reg;
            if (en6)
                vld6_reg <= vld5_reg;
            if (en7)
                vld7_reg <= vld6_reg;
            if (en8)
                vld8_reg <= vld7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            mode4_reg <= in_word.mode;
            up4_reg   <= in_word.up;
            acc4_reg  <= in_word.acc;
            sig4_reg  <= in_word.sig;
            xs4_reg   <= xs_next;
            xom4_reg  <= xom_next;
        end
        if (en5)
        begin
            mode5_reg  <= mode4_reg;
            up5_reg    <= up4_reg;
            acc5_reg   <= acc4_reg;
            sig5_reg   <= sig4_reg;
            act5_reg   <= act_next;
            ovf5_reg   <= act_ovf_next;
            inner5_reg <= inner_next;
        end
        if (en6)
        begin
            mode6_reg <= mode5_reg;
            up6_reg   <= up5_reg;
            acc6_reg  <= acc5_reg;
            act6_reg  <= act5_reg;
            ovf6_reg  <= ovf5_reg;
            g6_reg    <= g_next;
        end
        if (en7)
        begin
            mode7_reg <= mode6_reg;
            acc7_reg  <= acc6_reg;
            act7_reg  <= act6_reg;
            ovf7_reg  <= ovf6_reg;
            tp7_reg   <= tp_next;
        end
        if (en8)
        begin
            mode8_reg <= mode7_reg;
            act8_reg  <= act7_reg;
            grad8_reg <= grad_next;
            ovf8_reg  <= ovf_next;
        end
    end

    assign out_valid     = vld8_reg;
    assign out_word.act  = act8_reg;
    assign out_word.grad = grad8_reg;
    assign out_word.ovf  = ovf8_reg;

    `SWISH_ASSERT_IMPL(a_inner_one, vld5_reg && (sig5_reg == SIG_ONE), inner5_reg == INNER_ONE, "inner term wrong at full sigmoid")
    `SWISH_ASSERT_IMPL(a_fwd_grad, vld8_reg && !mode8_reg, grad8_reg == '0, "gradient set in forward mode")
    `SWISH_ASSERT_NEXT(a_res_hold, vld8_reg && out_stall, vld8_reg && $stable(act8_reg) && $stable(grad8_reg) && $stable(ovf8_reg), "stalled result word moved")

endmodule

@@ design/swish_activation_and_gradient.sv @@
// Top level of the swish activation and gradient pipeline.
// Depends on swish_pkg, swish_sigmoid and swish_grad.
//
//   channel | direction | handshake            | fields
//   req     | in        | req_valid, req_stall | mode, x_value, upstream_grad, grad_accum_in
//   rsp     | out       | rsp_valid, rsp_stall | activation, grad_accum_out, overflow
//
// One word per cycle sustained while rsp_stall is low; rsp_valid rises once the accepted word has passed all stages.
// Three sigmoid stages (index, table read, interpolation) feed five product stages.
// Reset clears only the stage valid bits; the sigmoid table is constant.
// rsp_stall holds the last stage; earlier stages keep advancing into empty slots.

module swish_activation_and_gradient (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               mode,
    input  logic signed [15:0] x_value,
    input  logic signed [15:0] upstream_grad,
    input  logic signed [15:0] grad_accum_in,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [15:0] activation,
    output logic signed [15:0] grad_accum_out,
    output logic               overflow
);
    import swish_pkg::*;

    logic            sig_valid;
    logic            sig_stall;
    swish_sig_word_t sig_word;
    swish_res_word_t res_word;

    swish_sigmoid u_sigmoid (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (req_valid),
        .in_stall      (req_stall),
        .mode          (mode),
        .x_value       (x_value),
        .upstream_grad (upstream_grad),
        .grad_accum_in (grad_accum_in),
        .out_valid     (sig_valid),
        .out_stall     (sig_stall),
        .out_word      (sig_word)
    );

    swish_grad u_grad (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sig_valid),
        .in_stall  (sig_stall),
        .in_word   (sig_word),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_word  (res_word)
    );

    assign activation     = res_word.act;
    assign grad_accum_out = res_word.grad;
    assign overflow       = res_word.ovf;

endmodule
